### design/script_line_tokenizer_top_assert.svh
// Assertion macros for the script line tokenizer.
`ifndef SCRIPT_LINE_TOKENIZER_TOP_ASSERT_SVH
`define SCRIPT_LINE_TOKENIZER_TOP_ASSERT_SVH

// same-cycle implication, disabled while in reset
`define SLT_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while in reset
`define SLT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### design/slt_pkg.sv
// Shared types, character codes and keyword table of the script line tokenizer.
package slt_pkg;

    localparam int MAX_LINE = 4096;
    localparam int TS_W = 12;
    localparam int TL_W = 13;

    localparam logic [2:0] MODE_SKIP   = 3'd0;
    localparam logic [2:0] MODE_PLAIN  = 3'd1;
    localparam logic [2:0] MODE_QUOTED = 3'd2;
    localparam logic [2:0] MODE_AFTERQ = 3'd3;
    localparam logic [2:0] MODE_DONE   = 3'd4;

    localparam logic [2:0] REG_COLLECT_EMPTY = 3'd0;

    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_LPAR   = 8'h28;
    localparam logic [7:0] CH_RPAR   = 8'h29;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_RBRACK = 8'h5D;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_UPPER_Z = 8'h5A;
    localparam logic [7:0] CASE_OFFSET = 8'h20;

    localparam int KW_N      = 16;
    localparam int KW_MAXLEN = 10;

    localparam logic [8*KW_MAXLEN-1:0] KW_TEXT [KW_N] = '{
        "var       ", "begin     ", "end       ", "while     ",
        "foreach   ", "loop      ", "if        ", "elseif    ",
        "else      ", "endif     ", "return    ", "call      ",
        "scn       ", "scriptname", "continue  ", "break     "
    };

    localparam logic [3:0] KW_LEN [KW_N] = '{
        4'd3, 4'd5, 4'd3, 4'd5, 4'd7, 4'd4, 4'd2, 4'd6,
        4'd4, 4'd5, 4'd6, 4'd4, 4'd3, 4'd10, 4'd8, 4'd5
    };

    localparam logic [3:0] KW_CLS [KW_N] = '{
        4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7, 4'd8,
        4'd9, 4'd10, 4'd11, 4'd12, 4'd13, 4'd13, 4'd14, 4'd15
    };

    typedef struct packed {
        logic            is_token;
        logic [TS_W-1:0] start;
        logic [TL_W-1:0] length;
        logic [7:0]      delim;
        logic [3:0]      kw;
        logic            found;
        logic            last;
    } t_rec;

    function automatic logic [7:0] kw_char(input int k, input logic [3:0] i);
        logic [7:0] ch;
        ch = 8'h00;
        if (int'(i) < KW_MAXLEN) begin
            ch = KW_TEXT[k][8*(KW_MAXLEN - 1 - int'(i)) +: 8];
        end
        return ch;
    endfunction

    function automatic logic is_delim(input logic [7:0] c);
        return c == CH_SEMI || c == CH_DOT || c == CH_COMMA || c == CH_SPACE ||
               c == CH_LPAR || c == CH_RPAR || c == CH_LBRACE || c == CH_RBRACE ||
               c == CH_LBRACK || c == CH_RBRACK || c == CH_TAB || c == CH_NL;
    endfunction

endpackage

### design/script_line_tokenizer_top.sv
// Top level of the script line tokenizer: input register, scan logic and record buffer.
// Bytes of one script line enter on the input channel, one per transfer, with
// i_is_last set on the final byte, after which an implicit newline is scanned.
// Each byte is registered on its transfer and scanned from that register; its records
// (token records, then the end-of-line summary) pass through the record buffer to the
// output channel, one record per transfer, the last record of a byte flagged by
// o_last_of_run. While the output is not stalled, a stream of ordinary text runs at
// one byte per clock; a byte yielding k records holds the single-record output port
// until all k are sent, which stalls the input while the record buffer drains.
// collect_empty sits at byte address 0 of the APB port and may only be written while
// the block is idle.
module script_line_tokenizer_top
    import slt_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_char_in,
    input  logic        i_is_last,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_is_token,
    output logic [11:0] o_token_start,
    output logic [12:0] o_token_length,
    output logic [7:0]  o_delimiter_char,
    output logic [3:0]  o_keyword,
    output logic        o_found_any,
    output logic        o_last_of_run,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int PW = $clog2(MAX_LINE + 1);
    localparam int SW = $clog2(MAX_LINE);

    typedef struct packed {
        logic [2:0]      mode;
        logic [PW-1:0]   pos;
        logic [SW-1:0]   pst;
        logic [PW-1:0]   plen;
        logic [KW_N-1:0] cand;
        logic            any;
    } t_state;

    typedef struct packed {
        t_state s;
        logic   emit;
        t_rec   rec;
    } t_feed;

    localparam t_state STATE_RESET = '{
        mode: MODE_SKIP, pos: '0, pst: '0, plen: '0, cand: '1, any: 1'b0
    };

    function automatic logic [PW-1:0] sat_inc(input logic [PW-1:0] p);
        return (p < PW'(MAX_LINE)) ? p + PW'(1) : p;
    endfunction

    function automatic logic [SW-1:0] clamp_start(input logic [PW:0] p);
        return (p > (PW+1)'(MAX_LINE - 1)) ? SW'(MAX_LINE - 1) : p[SW-1:0];
    endfunction

    function automatic logic [3:0] classify(input t_state s);
        logic [3:0] cls;
        logic       hit;
        cls = 4'd0;
        hit = 1'b0;
        for (int k = 0; k < KW_N; k++) begin
            if (!hit && s.cand[k] && s.plen == PW'(KW_LEN[k])) begin
                cls = KW_CLS[k];
                hit = 1'b1;
            end
        end
        return cls;
    endfunction

    function automatic t_state append(input t_state s, input logic [7:0] c);
        t_state ns;
        logic [7:0] lc;
        ns = s;
        lc = (c >= CH_UPPER_A && c <= CH_UPPER_Z) ? c + CASE_OFFSET : c;
        for (int k = 0; k < KW_N; k++) begin
            if (s.plen >= PW'(KW_LEN[k]) || kw_char(k, s.plen[3:0]) != lc) begin
                ns.cand[k] = 1'b0;
            end
        end
        ns.plen = sat_inc(s.plen);
        return ns;
    endfunction

    function automatic t_feed end_token(input t_state s, input logic [7:0] c,
                                        input logic ce);
        t_feed f;
        logic [PW:0] p1;
        f.s = s;
        f.rec = '0;
        p1 = {1'b0, s.pos} + (PW+1)'(1);
        if (c == CH_SEMI) begin
            f.emit = s.plen != '0;
            f.s.mode = MODE_DONE;
        end else begin
            f.emit = s.plen != '0 || ce;
            f.s.mode = MODE_PLAIN;
        end
        f.rec.is_token = 1'b1;
        f.rec.start = TS_W'(s.pst);
        f.rec.length = TL_W'(s.plen);
        f.rec.delim = c;
        f.rec.kw = classify(s);
        if (f.emit) begin
            f.s.any = 1'b1;
        end
        f.s.pst = clamp_start(p1);
        f.s.plen = '0;
        f.s.cand = '1;
        return f;
    endfunction

    function automatic t_feed feed(input t_state s, input logic [7:0] c,
                                   input logic imp, input logic ce);
        t_feed f;
        logic  go;
        f.s = s;
        f.emit = 1'b0;
        f.rec = '0;
        go = 1'b1;
        if (s.mode == MODE_SKIP) begin
            if (c == CH_SPACE || c == CH_TAB) begin
                go = 1'b0;
                f.s.pos = sat_inc(s.pos);
            end else begin
                f.s.pst = clamp_start({1'b0, s.pos});
                f.s.plen = '0;
                f.s.cand = '1;
                f.s.mode = MODE_PLAIN;
            end
        end
        if (go) begin
            unique case (f.s.mode)
                MODE_PLAIN: begin
                    if (is_delim(c)) begin
                        f = end_token(f.s, c, ce);
                    end else begin
                        if (f.s.plen == '0 && c == CH_QUOTE) begin
                            f.s.mode = MODE_QUOTED;
                        end
                        f.s = append(f.s, c);
                    end
                end
                MODE_QUOTED: begin
                    if (imp) begin
                        f = end_token(f.s, c, ce);
                    end else begin
                        f.s = append(f.s, c);
                        if (c == CH_QUOTE) begin
                            f.s.mode = MODE_AFTERQ;
                        end
                    end
                end
                MODE_AFTERQ: begin
                    f = end_token(f.s, c, ce);
                end
                default: begin
                    f.s.mode = MODE_DONE;
                end
            endcase
            f.s.pos = sat_inc(f.s.pos);
        end
        return f;
    endfunction

    logic       r_collect_empty;
    logic       r_in_valid;
    logic [7:0] r_char;
    logic       r_last;
    t_state     r_st;
    t_state     n_st;
    t_rec       r_rec [3];
    t_rec       n_rec [3];
    logic [1:0] r_cnt;
    logic [1:0] n_cnt;

    t_feed      f_byte;
    t_feed      f_nl;
    t_rec       summary;
    logic       out_xfer;
    logic       proc;
    logic       cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign prdata = (paddr == REG_COLLECT_EMPTY) ? {31'b0, r_collect_empty} : 32'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_collect_empty <= 1'b0;
        end else if (cfg_wr && paddr == REG_COLLECT_EMPTY) begin
            r_collect_empty <= pwdata[0];
        end
    end

    always_comb begin
        f_byte = feed(r_st, r_char, 1'b0, r_collect_empty);
        f_nl = feed(f_byte.s, CH_NL, 1'b1, r_collect_empty);
        summary = '0;
        summary.found = f_nl.s.any;
        n_rec = '{default: '0};
        n_cnt = 2'd0;
        if (f_byte.emit) begin
            n_rec[n_cnt] = f_byte.rec;
            n_cnt = n_cnt + 2'd1;
        end
        if (r_last) begin
            if (f_nl.emit) begin
                n_rec[n_cnt] = f_nl.rec;
                n_cnt = n_cnt + 2'd1;
            end
            n_rec[n_cnt] = summary;
            n_cnt = n_cnt + 2'd1;
        end
        if (n_cnt != 2'd0) begin
            n_rec[n_cnt - 2'd1].last = 1'b1;
        end
        n_st = r_last ? STATE_RESET : f_byte.s;
    end

    assign o_out_valid = r_cnt != 2'd0;
    assign out_xfer    = o_out_valid && !i_out_stall;
    assign proc        = r_in_valid &&
                         (n_cnt == 2'd0 || r_cnt == 2'd0 || (r_cnt == 2'd1 && out_xfer));
    assign o_in_stall  = r_in_valid && !proc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_st <= STATE_RESET;
            r_cnt <= 2'd0;
        end else begin
            if (!o_in_stall) begin
                r_in_valid <= i_in_valid;
            end
            if (proc) begin
                r_st <= n_st;
            end
            if (proc && n_cnt != 2'd0) begin
                r_cnt <= n_cnt;
            end else if (out_xfer) begin
                r_cnt <= r_cnt - 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_char <= i_char_in;
            r_last <= i_is_last;
        end
        if (proc && n_cnt != 2'd0) begin
            r_rec <= n_rec;
        end else if (out_xfer) begin
            r_rec[0] <= r_rec[1];
            r_rec[1] <= r_rec[2];
        end
    end

    assign o_is_token       = r_rec[0].is_token;
    assign o_token_start    = r_rec[0].start;
    assign o_token_length   = r_rec[0].length;
    assign o_delimiter_char = r_rec[0].delim;
    assign o_keyword        = r_rec[0].kw;
    assign o_found_any      = r_rec[0].found;
    assign o_last_of_run    = r_rec[0].last;

endmodule

### design/slt_checker.sv
// Port-level checker for the script line tokenizer and its bind.
`include "script_line_tokenizer_top_assert.svh"

module slt_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic        o_is_token,
    input logic [11:0] o_token_start,
    input logic [12:0] o_token_length,
    input logic [7:0]  o_delimiter_char,
    input logic [3:0]  o_keyword,
    input logic        o_found_any,
    input logic        o_last_of_run
);

    `SLT_ASSERT_NOW(a_summary_ends_run, i_clk, i_rst_n, o_out_valid && !o_is_token, o_last_of_run, "summary record not flagged last of run")
    `SLT_ASSERT_NOW(a_summary_zero, i_clk, i_rst_n, o_out_valid && !o_is_token, o_token_start == 12'd0 && o_token_length == 13'd0 && o_delimiter_char == 8'd0 && o_keyword == 4'd0, "summary record carries token fields")
    `SLT_ASSERT_NOW(a_token_no_found, i_clk, i_rst_n, o_out_valid && o_is_token, !o_found_any, "token record has found_any set")
    `SLT_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid && $stable(o_is_token) && $stable(o_token_start) && $stable(o_token_length) && $stable(o_delimiter_char) && $stable(o_keyword) && $stable(o_found_any) && $stable(o_last_of_run), "stalled record changed")

endmodule

bind script_line_tokenizer_top slt_checker u_slt_checker (.*);
